// ===== sv/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants for the homogeneous point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

    // Word width of coordinates and matrix elements.
    localparam int DATA_W   = 32;
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 3;

    // Saturation limits of a signed 32-bit word.
    localparam logic [DATA_W-1:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    // Operation codes.
    localparam logic OP_POINT  = 1'b0;
    localparam logic OP_VECTOR = 1'b1;

    // Matrix registers: two elements per register, even column low.
    typedef logic [NUM_REGS-1:0][2*DATA_W-1:0] mat_t;

    // Three result lanes.
    typedef logic [2:0][DATA_W-1:0] lanes_t;

    // Per-item control that travels along the divider pipeline.
    typedef struct packed {
        logic vec;
        logic zero_w;
        logic sat;
    } side_t;

endpackage

// ===== sv/hpt_dot.sv =====
// ----------------------------------------------------------------------------
// hpt_dot
// Four dot products of the matrix rows with (x, y, z, 1 or 0), in three
// register stages: multiply, wide sum, truncate and saturate.
// ----------------------------------------------------------------------------
module hpt_dot #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        vld_i,
    input  logic                        op_i,
    input  logic [hpt_pkg::DATA_W-1:0]  x_i,
    input  logic [hpt_pkg::DATA_W-1:0]  y_i,
    input  logic [hpt_pkg::DATA_W-1:0]  z_i,
    input  hpt_pkg::mat_t               mat_i,
    output logic                        vld_o,
    output logic                        op_o,
    output logic [3:0][hpt_pkg::DATA_W-1:0] res_o,
    output logic [3:0]                  sat_o
);

    localparam int DW = hpt_pkg::DATA_W;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 2;

    logic signed [PW-1:0] prod_reg [0:3][0:2];
    logic signed [PW-1:0] bias_reg [0:3];
    logic signed [SW-1:0] sum_reg  [0:3];
    logic        [DW-1:0] res_reg  [0:3];
    logic        [3:0]    sat_reg;
    logic [2:0] vld_reg;
    logic [2:0] op_reg;

    logic signed [DW-1:0] vin [0:2];

    assign vin[0] = x_i;
    assign vin[1] = y_i;
    assign vin[2] = z_i;

    // Valid and mode bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[1:0], vld_i};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg <= {op_reg[1:0], op_i};
        end
    end

    genvar r, c;
    generate
        for (r = 0; r < 4; r++)
        begin : g_row
            logic signed [DW-1:0] e3;
            logic signed [SW-1:0] t;
            logic                 ovf;

            assign e3 = mat_i[r*2 + 1][DW +: DW];

            // Stage 1: element products, and the translation term as a shift.
            for (c = 0; c < 3; c++)
            begin : g_col
                logic signed [DW-1:0] e;
                assign e = mat_i[r*2 + c/2][(c%2)*DW +: DW];
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        prod_reg[r][c] <= e * vin[c];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    bias_reg[r] <= (op_i == hpt_pkg::OP_POINT) ?
                                   (PW'(e3) <<< FRAC_BITS) : '0;
                end
            end

            // Stage 2: exact wide sum.
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sum_reg[r] <= SW'(prod_reg[r][0]) + SW'(prod_reg[r][1])
                                + SW'(prod_reg[r][2]) + SW'(bias_reg[r]);
                end
            end

            // Stage 3: drop fraction bits toward minus infinity and saturate.
            assign t   = sum_reg[r] >>> FRAC_BITS;
            assign ovf = (t[SW-1:DW-1] != {(SW-DW+1){t[DW-1]}});

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    res_reg[r] <= ovf ? (t[SW-1] ? hpt_pkg::Q_MIN : hpt_pkg::Q_MAX)
                                      : t[DW-1:0];
                    sat_reg[r] <= ovf;
                end
            end

            assign res_o[r] = res_reg[r];
        end
    endgenerate

    assign vld_o = vld_reg[2];
    assign op_o  = op_reg[2];
    assign sat_o = sat_reg;

endmodule

// ===== sv/hpt_div.sv =====
// ----------------------------------------------------------------------------
// hpt_div
// Pipelined restoring divider for the perspective divide: three lanes
// share one divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hpt_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        vld_i,
    input  hpt_pkg::lanes_t             res_i,
    input  logic [hpt_pkg::DATA_W-1:0]  w_i,
    input  hpt_pkg::side_t              side_i,
    output logic                        vld_o,
    output hpt_pkg::lanes_t             res_o,
    output hpt_pkg::lanes_t             quot_o,
    output logic                        qsat_o,
    output hpt_pkg::side_t              side_o
);

    localparam int DW = hpt_pkg::DATA_W;
    localparam int QW = DW + FRAC_BITS;
    localparam logic [QW-1:0] POS_LIM = QW'(hpt_pkg::Q_MAX);
    localparam logic [QW-1:0] NEG_LIM = QW'(hpt_pkg::Q_MIN);

    logic [QW-1:0]   dq_reg   [0:QW][0:2];
    logic [DW-1:0]   rem_reg  [0:QW][0:2];
    logic [2:0]      neg_reg  [0:QW];
    logic [DW-1:0]   d_reg    [0:QW];
    hpt_pkg::lanes_t res_reg  [0:QW];
    hpt_pkg::side_t  side_reg [0:QW];
    logic [QW:0]     vld_reg;

    logic [DW-1:0] w_mag;

    assign w_mag = w_i[DW-1] ? (~w_i + 1'b1) : w_i;

    // Valid bits of all stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[QW-1:0], vld_i};
        end
    end

    // Stage 0: magnitudes and signs.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0]    <= w_mag;
            res_reg[0]  <= res_i;
            side_reg[0] <= side_i;
        end
    end

    genvar l, s;
    generate
        for (l = 0; l < 3; l++)
        begin : g_prep
            logic [DW-1:0] n_mag;
            assign n_mag = res_i[l][DW-1] ? (~res_i[l] + 1'b1) : res_i[l];
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dq_reg[0][l]  <= {n_mag, {FRAC_BITS{1'b0}}};
                    rem_reg[0][l] <= '0;
                    neg_reg[0][l] <= res_i[l][DW-1] ^ w_i[DW-1];
                end
            end
        end

        // Stages 1..QW: one restoring step each.
        for (s = 1; s <= QW; s++)
        begin : g_stage
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    d_reg[s]    <= d_reg[s-1];
                    neg_reg[s]  <= neg_reg[s-1];
                    res_reg[s]  <= res_reg[s-1];
                    side_reg[s] <= side_reg[s-1];
                end
            end

            for (l = 0; l < 3; l++)
            begin : g_lane
                logic [DW:0] trial;
                logic [DW:0] diff;
                logic        fits;
                assign trial = {rem_reg[s-1][l], dq_reg[s-1][l][QW-1]};
                assign diff  = trial - {1'b0, d_reg[s-1]};
                assign fits  = (trial >= {1'b0, d_reg[s-1]});
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        rem_reg[s][l] <= fits ? diff[DW-1:0] : trial[DW-1:0];
                        dq_reg[s][l]  <= {dq_reg[s-1][l][QW-2:0], fits};
                    end
                end
            end
        end

        // Sign and saturation of the quotients.
        logic [2:0] lsat;
        for (l = 0; l < 3; l++)
        begin : g_fin
            logic [QW-1:0] q;
            assign q = dq_reg[QW][l];
            always_comb
            begin
                if (neg_reg[QW][l])
                begin
                    lsat[l]   = (q > NEG_LIM);
                    quot_o[l] = lsat[l] ? hpt_pkg::Q_MIN : (~q[DW-1:0] + 1'b1);
                end
                else
                begin
                    lsat[l]   = (q > POS_LIM);
                    quot_o[l] = lsat[l] ? hpt_pkg::Q_MAX : q[DW-1:0];
                end
            end
        end
        assign qsat_o = |lsat;
    endgenerate

    assign vld_o  = vld_reg[QW];
    assign res_o  = res_reg[QW];
    assign side_o = side_reg[QW];

endmodule

// ===== sv/homogeneous_point_transform.sv =====
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 homogeneous transform of Q16.16 points and vectors with divide by w.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_stall with op, in_x, in_y, in_z. op selects a
//   point (w = 1, divide by w) or a direction vector (upper 3x3 only).
//   Output channel: out_valid/out_stall with out_x, out_y, out_z, zero_w and
//   saturated; one result per input, in order.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; it is
//   always ready. Write it only while no item is in flight.
// Throughput is one item per cycle while the output is not stalled. An
// input transfer reaches out_valid through three stages for the dot
// products, one for operand magnitudes, 32 + FRAC_BITS stages of the
// bit-per-stage divider, and the output register.
// Reset loads the identity matrix and empties the pipeline.
// While the output is stalled with a result waiting, the whole pipeline
// holds and in_stall is raised; no transfer is lost or repeated.
// ----------------------------------------------------------------------------
module homogeneous_point_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [hpt_pkg::IDX_W-1:0]    cfg_index,
    input  logic [2*hpt_pkg::DATA_W-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic signed [hpt_pkg::DATA_W-1:0] in_x,
    input  logic signed [hpt_pkg::DATA_W-1:0] in_y,
    input  logic signed [hpt_pkg::DATA_W-1:0] in_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [hpt_pkg::DATA_W-1:0] out_x,
    output logic signed [hpt_pkg::DATA_W-1:0] out_y,
    output logic signed [hpt_pkg::DATA_W-1:0] out_z,
    output logic                         zero_w,
    output logic                         saturated
);

    localparam int DW = hpt_pkg::DATA_W;

    hpt_pkg::mat_t mat_reg;
    logic          adv;

    logic                 dot_vld;
    logic                 dot_op;
    logic [3:0][DW-1:0]   dot_res;
    logic [3:0]           dot_sat;
    hpt_pkg::lanes_t      dot_lanes;
    hpt_pkg::side_t       dot_side;
    logic                 is_point;
    logic                 w_zero;

    logic                 div_vld;
    hpt_pkg::lanes_t      div_res;
    hpt_pkg::lanes_t      div_quot;
    logic                 div_qsat;
    hpt_pkg::side_t       div_side;

    hpt_pkg::lanes_t      out_res_reg;
    logic                 out_valid_reg;
    logic                 zero_w_reg;
    logic                 sat_reg;

    // The pipeline moves unless a finished result is held by the receiver.
    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    // Matrix registers; reset gives the identity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg    <= '0;
            mat_reg[0] <= 64'h0000_0000_0001_0000;
            mat_reg[2] <= 64'h0001_0000_0000_0000;
            mat_reg[5] <= 64'h0000_0000_0001_0000;
            mat_reg[7] <= 64'h0001_0000_0000_0000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mat_reg[cfg_index] <= cfg_data;
        end
    end

    hpt_dot #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dot (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .vld_i (in_valid),
        .op_i  (op),
        .x_i   (in_x),
        .y_i   (in_y),
        .z_i   (in_z),
        .mat_i (mat_reg),
        .vld_o (dot_vld),
        .op_o  (dot_op),
        .res_o (dot_res),
        .sat_o (dot_sat)
    );

    // Flags after the dot products: w only counts in point mode.
    assign is_point = (dot_op == hpt_pkg::OP_POINT);
    assign w_zero   = is_point && (dot_res[3] == '0);
    assign dot_lanes       = dot_res[2:0];
    assign dot_side.vec    = !is_point;
    assign dot_side.zero_w = w_zero;
    assign dot_side.sat    = !w_zero &&
                             (|dot_sat[2:0] || (is_point && dot_sat[3]));

    hpt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .vld_i  (dot_vld),
        .res_i  (dot_lanes),
        .w_i    (dot_res[3]),
        .side_i (dot_side),
        .vld_o  (div_vld),
        .res_o  (div_res),
        .quot_o (div_quot),
        .qsat_o (div_qsat),
        .side_o (div_side)
    );

    // Output register with the mode selection.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_w_reg <= div_side.zero_w;
            if (div_side.vec)
            begin
                out_res_reg <= div_res;
                sat_reg     <= div_side.sat;
            end
            else if (div_side.zero_w)
            begin
                out_res_reg <= '0;
                sat_reg     <= 1'b0;
            end
            else
            begin
                out_res_reg <= div_quot;
                sat_reg     <= div_side.sat || div_qsat;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_res_reg[0];
    assign out_y     = out_res_reg[1];
    assign out_z     = out_res_reg[2];
    assign zero_w    = zero_w_reg;
    assign saturated = sat_reg;

endmodule

// ===== sv/hpt_checker.sv =====
// ----------------------------------------------------------------------------
// hpt_checker
// Port-level checks of the homogeneous point transform, bound to the top.
// ----------------------------------------------------------------------------
module hpt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [hpt_pkg::DATA_W-1:0]   out_x,
    input logic [hpt_pkg::DATA_W-1:0]   out_y,
    input logic [hpt_pkg::DATA_W-1:0]   out_z,
    input logic                         zero_w,
    input logic                         saturated
);

    // A stalled result stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped during stall");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_x) && $stable(out_y)
                                   && $stable(out_z) && $stable(zero_w)
                                   && $stable(saturated))
        else $error("output payload changed during stall");

    // The input is only held back by a waiting result.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // A zero w gives zero coordinates and no saturation.
    a_zero_w: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_w |-> out_x == '0 && out_y == '0 && out_z == '0
                                && !saturated)
        else $error("zero_w result not cleared");

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .zero_w    (zero_w),
    .saturated (saturated)
);
